// ===== design/stl_pkg.sv =====
// Shared types, codes and helpers for the source token lexer.
`timescale 1ns / 1ps

package stl_pkg;

	localparam int INPUT_LIMIT = 65536;
	localparam logic [15:0] OFF_MAX = (INPUT_LIMIT - 1 > 65535) ? 16'hFFFF
		: 16'(INPUT_LIMIT - 1);
	localparam logic [15:0] LINE_MAX = 16'hFFFF;

	localparam logic [47:0] KW_FN     = 48'("fn");
	localparam logic [47:0] KW_LET    = 48'("let");
	localparam logic [47:0] KW_RETURN = 48'("return");
	localparam logic [47:0] KW_IF     = 48'("if");
	localparam logic [47:0] KW_WHILE  = 48'("while");

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_BANG  = 8'h21;

	typedef enum logic [3:0] {
		M_IDLE, M_WORD, M_NUMBER, M_STRING, M_COMMENT, M_SLASH, M_EQ, M_BANG
	} mode_t;

	typedef enum logic [4:0] {
		K_FN = 5'd0, K_LET, K_RETURN, K_IF, K_WHILE,
		K_LPAREN, K_RPAREN, K_LBRACE, K_RBRACE,
		K_PLUS, K_MINUS, K_STAR, K_SLASH,
		K_ASSIGN, K_EQ, K_NE, K_COMMA, K_SEMI,
		K_IDENT, K_STRING, K_NUMBER, K_EOF
	} tok_kind_t;

	typedef enum logic [1:0] {
		ST_OK, ST_BAD_CHAR, ST_OPEN_STRING
	} status_t;

	typedef struct packed {
		tok_kind_t   kind;
		logic [15:0] start_offset;
		logic [15:0] text_length;
		logic [15:0] line;
		status_t     status;
		logic [7:0]  bad_char;
		logic        last;
	} tok_res_t;

	function automatic logic [15:0] sat_off(input logic [15:0] x);
		return (x < OFF_MAX) ? x + 16'd1 : OFF_MAX;
	endfunction

	function automatic logic [15:0] sat_line(input logic [15:0] x);
		return (x < LINE_MAX) ? x + 16'd1 : LINE_MAX;
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_punct(input logic [7:0] c);
		return c inside {"(", ")", "{", "}", ";", ",", "+", "-", "*"};
	endfunction

	function automatic tok_kind_t punct_kind(input logic [7:0] c);
		tok_kind_t k;
		case (c)
			"(": k = K_LPAREN;
			")": k = K_RPAREN;
			"{": k = K_LBRACE;
			"}": k = K_RBRACE;
			";": k = K_SEMI;
			",": k = K_COMMA;
			"+": k = K_PLUS;
			"-": k = K_MINUS;
			"*": k = K_STAR;
			default: k = K_FN;
		endcase
		return k;
	endfunction

	// prefix holds up to the first six letters, right aligned
	function automatic tok_kind_t word_kind(input logic [47:0] w, input logic [15:0] len);
		tok_kind_t k;
		if (len == 16'd2 && w == KW_FN) k = K_FN;
		else if (len == 16'd3 && w == KW_LET) k = K_LET;
		else if (len == 16'd6 && w == KW_RETURN) k = K_RETURN;
		else if (len == 16'd2 && w == KW_IF) k = K_IF;
		else if (len == 16'd5 && w == KW_WHILE) k = K_WHILE;
		else k = K_IDENT;
		return k;
	endfunction

endpackage

// ===== design/stl_ifs.sv =====
// Valid/ready channel interfaces for source bytes and tokens.
`timescale 1ns / 1ps

interface stl_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       end_of_input;

	modport source (output valid, output ch, output end_of_input, input ready);
	modport sink (input valid, input ch, input end_of_input, output ready);
endinterface

interface stl_token_if;
	logic        valid;
	logic        ready;
	logic [4:0]  token_kind;
	logic [15:0] start_offset;
	logic [15:0] text_length;
	logic [15:0] line;
	logic [1:0]  status;
	logic [7:0]  bad_char;
	logic        last;

	modport source (output valid, output token_kind, output start_offset,
		output text_length, output line, output status, output bad_char,
		output last, input ready);
	modport sink (input valid, input token_kind, input start_offset,
		input text_length, input line, input status, input bad_char,
		input last, output ready);
endinterface

// ===== design/source_token_lexer_unit.sv =====
// Streaming lexer: one source byte per word in, tokens out.
`timescale 1ns / 1ps

//  channel | dir | word                                   | handshake
//  text    | in  | ch, end_of_input                       | valid/ready
//  tokens  | out | token_kind, start_offset, text_length, | valid/ready
//          |     | line, status, bad_char, last           |
//
// One byte per cycle while text.ready is high. Each accepted word is lexed
// in the accept cycle and its zero, one or two tokens land in a four-entry
// result queue; the queue is registered and tokens shows its oldest entry.
// text.ready is high while at least two queue slots are free, so a word that
// yields two tokens always fits. arst_n clears the lexer state and the queue.
// After an error token all words are taken and dropped until reset.

module source_token_lexer_unit import stl_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	stl_text_if.sink    text,
	stl_token_if.source tokens
);

	localparam int Q_DEPTH = 4;
	localparam int Q_AW = $clog2(Q_DEPTH);

	// lexer state
	mode_t       mode_q, mode_n;
	logic [15:0] position_q, position_n;
	logic [15:0] line_count_q, line_count_n;
	logic [15:0] token_start_q, token_start_n;
	logic [15:0] token_length_q, token_length_n;
	logic [15:0] token_line_q, token_line_n;
	logic [47:0] word_prefix_q, word_prefix_n;
	logic        halted_q, halted_n;

	// result queue
	tok_res_t        fifo_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_AW:0]   cnt_q;

	logic       take, eoi, pop;
	logic [7:0] c;
	logic       c_letter, c_digit, c_punct, c_quiet;

	// step decode
	tok_res_t  fin_res, b_res, res0, res1;
	logic      fin_v, st_run, st_emit, eof_v, b_v, halt_set;
	tok_kind_t wk;
	logic [1:0] push_n;

	assign c        = text.ch;
	assign eoi      = text.end_of_input;
	assign take     = text.valid && text.ready && !halted_q;
	assign c_letter = is_letter(c);
	assign c_digit  = is_digit(c);
	assign c_punct  = is_punct(c);
	assign c_quiet  = c_letter || c_digit
		|| (c inside {CH_SPACE, CH_TAB, CH_CR, CH_NL, CH_SLASH, CH_EQ, CH_BANG, CH_QUOTE});
	assign wk       = word_kind(word_prefix_q, token_length_q);

	// what the word finishes (fin) and whether the byte starts afresh (st_run)
	always_comb begin
		fin_v   = 1'b0;
		fin_res = '{kind: K_FN, start_offset: token_start_q, text_length: 16'd0,
			line: token_line_q, status: ST_OK, bad_char: 8'd0, last: 1'b0};
		st_run  = 1'b0;
		eof_v   = 1'b0;
		if (take) begin
			if (eoi) begin
				eof_v = !(mode_q == M_BANG || mode_q == M_STRING);
				case (mode_q)
					M_WORD: begin
						fin_v = 1'b1;
						fin_res.kind = wk;
						fin_res.text_length = (wk == K_IDENT) ? token_length_q : 16'd0;
					end
					M_NUMBER: begin
						fin_v = 1'b1;
						fin_res.kind = K_NUMBER;
						fin_res.text_length = token_length_q;
					end
					M_SLASH: begin
						fin_v = 1'b1;
						fin_res.kind = K_SLASH;
					end
					M_EQ: begin
						fin_v = 1'b1;
						fin_res.kind = K_ASSIGN;
					end
					M_BANG: begin
						fin_v = 1'b1;
						fin_res.status = ST_BAD_CHAR;
						fin_res.bad_char = CH_BANG;
					end
					M_STRING: begin
						fin_v = 1'b1;
						fin_res.status = ST_OPEN_STRING;
					end
					default: ;
				endcase
			end else begin
				case (mode_q)
					M_WORD: begin
						if (!c_letter) begin
							fin_v = 1'b1;
							fin_res.kind = wk;
							fin_res.text_length = (wk == K_IDENT) ? token_length_q : 16'd0;
							st_run = 1'b1;
						end
					end
					M_NUMBER: begin
						if (!c_digit) begin
							fin_v = 1'b1;
							fin_res.kind = K_NUMBER;
							fin_res.text_length = token_length_q;
							st_run = 1'b1;
						end
					end
					M_STRING: begin
						if (c == CH_QUOTE) begin
							fin_v = 1'b1;
							fin_res.kind = K_STRING;
							fin_res.text_length = token_length_q;
						end
					end
					M_COMMENT: st_run = (c == CH_NL);
					M_SLASH: begin
						if (c != CH_SLASH) begin
							fin_v = 1'b1;
							fin_res.kind = K_SLASH;
							st_run = 1'b1;
						end
					end
					M_EQ: begin
						fin_v = 1'b1;
						fin_res.kind = (c == CH_EQ) ? K_EQ : K_ASSIGN;
						st_run = (c != CH_EQ);
					end
					M_BANG: begin
						fin_v = 1'b1;
						if (c == CH_EQ) begin
							fin_res.kind = K_NE;
						end else begin
							// lone bang: the byte after it is dropped
							fin_res.status = ST_BAD_CHAR;
							fin_res.bad_char = CH_BANG;
						end
					end
					default: st_run = 1'b1;
				endcase
			end
		end
	end

	assign st_emit  = st_run && !c_quiet;
	assign halt_set = (fin_v && fin_res.status != ST_OK)
		|| (st_emit && !c_punct);

	// next state
	always_comb begin
		mode_n         = mode_q;
		position_n     = position_q;
		line_count_n   = line_count_q;
		token_start_n  = token_start_q;
		token_length_n = token_length_q;
		token_line_n   = token_line_q;
		word_prefix_n  = word_prefix_q;
		halted_n       = halted_q || halt_set;
		if (take) begin
			if (eoi) begin
				if (eof_v) begin
					mode_n         = M_IDLE;
					position_n     = 16'd0;
					line_count_n   = 16'd1;
					token_start_n  = 16'd0;
					token_length_n = 16'd0;
					token_line_n   = 16'd1;
					word_prefix_n  = 48'd0;
				end
			end else begin
				position_n = sat_off(position_q);
				case (mode_q)
					M_WORD: begin
						if (c_letter) begin
							if (token_length_q < 16'd6) word_prefix_n = {word_prefix_q[39:0], c};
							token_length_n = sat_off(token_length_q);
						end
					end
					M_NUMBER: begin
						if (c_digit) token_length_n = sat_off(token_length_q);
					end
					M_STRING: begin
						if (c == CH_QUOTE) mode_n = M_IDLE;
						else token_length_n = sat_off(token_length_q);
					end
					M_SLASH: begin
						if (c == CH_SLASH) mode_n = M_COMMENT;
					end
					M_EQ, M_BANG: begin
						if (c == CH_EQ) mode_n = M_IDLE;
					end
					default: ;
				endcase
				if (st_run) begin
					mode_n = M_IDLE;
					if (c_letter || c_digit || c == CH_SLASH || c == CH_EQ || c == CH_BANG
							|| c == CH_QUOTE) begin
						token_start_n  = (c == CH_QUOTE) ? sat_off(position_q) : position_q;
						token_length_n = (c_letter || c_digit) ? 16'd1 : 16'd0;
						token_line_n   = line_count_q;
					end
					if (c_letter) begin
						mode_n = M_WORD;
						word_prefix_n = {40'd0, c};
					end else if (c_digit) begin
						mode_n = M_NUMBER;
					end else if (c == CH_NL) begin
						line_count_n = sat_line(line_count_q);
					end else if (c == CH_SLASH) begin
						mode_n = M_SLASH;
					end else if (c == CH_EQ) begin
						mode_n = M_EQ;
					end else if (c == CH_BANG) begin
						mode_n = M_BANG;
					end else if (c == CH_QUOTE) begin
						mode_n = M_STRING;
					end
				end
			end
		end
	end

	// results of this word, in order
	always_comb begin
		b_res = '{kind: K_FN, start_offset: position_q, text_length: 16'd0,
			line: line_count_q, status: ST_OK, bad_char: 8'd0, last: 1'b0};
		if (eoi) begin
			b_v = eof_v;
			b_res.kind = K_EOF;
		end else begin
			b_v = st_emit;
			if (c_punct) begin
				b_res.kind = punct_kind(c);
			end else begin
				b_res.status = ST_BAD_CHAR;
				b_res.bad_char = c;
			end
		end
		push_n = {1'b0, fin_v} + {1'b0, b_v};
		res0 = fin_v ? fin_res : b_res;
		res0.last = (push_n == 2'd1);
		res1 = b_res;
		res1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= M_IDLE;
			position_q     <= 16'd0;
			line_count_q   <= 16'd1;
			token_start_q  <= 16'd0;
			token_length_q <= 16'd0;
			token_line_q   <= 16'd1;
			word_prefix_q  <= 48'd0;
			halted_q       <= 1'b0;
		end else begin
			mode_q         <= mode_n;
			position_q     <= position_n;
			line_count_q   <= line_count_n;
			token_start_q  <= token_start_n;
			token_length_q <= token_length_n;
			token_line_q   <= token_line_n;
			word_prefix_q  <= word_prefix_n;
			halted_q       <= halted_n;
		end
	end

	// result queue
	assign pop = tokens.valid && tokens.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + Q_AW'(push_n);
			rd_ptr_q <= rd_ptr_q + Q_AW'(pop);
			cnt_q    <= cnt_q + (Q_AW+1)'(push_n) - (Q_AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) fifo_q[wr_ptr_q] <= res0;
		if (push_n == 2'd2) fifo_q[wr_ptr_q + Q_AW'(1)] <= res1;
	end

	assign text.ready = cnt_q <= (Q_AW+1)'(Q_DEPTH - 2);

	assign tokens.valid        = cnt_q != '0;
	assign tokens.token_kind   = fifo_q[rd_ptr_q].kind;
	assign tokens.start_offset = fifo_q[rd_ptr_q].start_offset;
	assign tokens.text_length  = fifo_q[rd_ptr_q].text_length;
	assign tokens.line         = fifo_q[rd_ptr_q].line;
	assign tokens.status       = fifo_q[rd_ptr_q].status;
	assign tokens.bad_char     = fifo_q[rd_ptr_q].bad_char;
	assign tokens.last         = fifo_q[rd_ptr_q].last;

`ifndef SYNTHESIS
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (Q_AW+1)'(Q_DEPTH))
		else $error("result queue overflow");

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halt cleared without reset");

	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |-> push_n == 2'd0)
		else $error("token produced while halted");

	a_error_halts: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n != 2'd0 && res0.status != ST_OK) |=> halted_q)
		else $error("error token without halt");
`endif

endmodule
